### rtl/ptc_pkg.sv
`default_nettype none

package ptc_pkg;

    localparam int CountW = 8;
    localparam int PhaseW = 10;
    localparam int CmdW   = 2;
    localparam int ModeW  = 3;
    localparam int CsW    = 3;
    localparam int ActW   = 2;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 3;

    localparam logic [CountW-1:0] COUNT_MAX = 8'hFF;

    // Item commands.
    localparam logic [CmdW-1:0] CMD_TICK = 2'd0;
    localparam logic [CmdW-1:0] CMD_WR_A = 2'd1;
    localparam logic [CmdW-1:0] CMD_WR_B = 2'd2;

    // Pin actions.
    localparam logic [ActW-1:0] ACT_NONE   = 2'd0;
    localparam logic [ActW-1:0] ACT_TOGGLE = 2'd1;
    localparam logic [ActW-1:0] ACT_CLEAR  = 2'd2;
    localparam logic [ActW-1:0] ACT_SET    = 2'd3;

    // Clock select codes.
    localparam logic [CsW-1:0] CS_DIV1    = 3'd1;
    localparam logic [CsW-1:0] CS_DIV8    = 3'd2;
    localparam logic [CsW-1:0] CS_DIV64   = 3'd3;
    localparam logic [CsW-1:0] CS_DIV256  = 3'd4;
    localparam logic [CsW-1:0] CS_DIV1024 = 3'd5;

    // Waveform modes.
    localparam logic [ModeW-1:0] MODE_NORMAL      = 3'd0;
    localparam logic [ModeW-1:0] MODE_PWM_PC      = 3'd1;
    localparam logic [ModeW-1:0] MODE_CTC         = 3'd2;
    localparam logic [ModeW-1:0] MODE_PWM_FAST    = 3'd3;
    localparam logic [ModeW-1:0] MODE_PWM_PC_OCR  = 3'd5;
    localparam logic [ModeW-1:0] MODE_PWM_FAST_OCR = 3'd7;

    // Configuration register indexes.
    localparam logic [CfgAddrW-1:0] REG_WAVE_MODE    = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_CLOCK_SELECT = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_ACTION_A     = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_ACTION_B     = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_DRIVE_A      = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_DRIVE_B      = 3'd5;

    typedef struct packed {
        logic [ModeW-1:0] wave_mode;
        logic [CsW-1:0]   clock_select;
        logic [ActW-1:0]  action_a;
        logic [ActW-1:0]  action_b;
        logic             drive_a;
        logic             drive_b;
    } cfg_t;

    typedef struct packed {
        logic             pin_b;
        logic             pin_a;
        logic             match_b_flag;
        logic             match_a_flag;
        logic             overflow_flag;
        logic [CountW-1:0] count;
    } result_t;

    function automatic logic mode_is_pwm(input logic [ModeW-1:0] mode);
        return (mode == MODE_PWM_PC) || (mode == MODE_PWM_FAST) ||
               (mode == MODE_PWM_PC_OCR) || (mode == MODE_PWM_FAST_OCR);
    endfunction

    function automatic logic mode_is_plain(input logic [ModeW-1:0] mode);
        return (mode == MODE_NORMAL) || (mode == MODE_CTC);
    endfunction

    function automatic logic mode_top_is_ocr(input logic [ModeW-1:0] mode);
        return (mode == MODE_CTC) || (mode == MODE_PWM_PC_OCR) ||
               (mode == MODE_PWM_FAST_OCR);
    endfunction

    function automatic logic wrap_action(input logic [ActW-1:0] act, input logic lvl);
        logic res;
        case (act)
            ACT_CLEAR: res = 1'b1;
            ACT_SET:   res = 1'b0;
            default:   res = lvl;
        endcase
        return res;
    endfunction

    function automatic logic match_action(input logic [ModeW-1:0] mode,
                                          input logic [ActW-1:0] act,
                                          input logic lvl);
        logic res;
        res = lvl;
        if (mode_is_plain(mode) || mode_is_pwm(mode)) begin
            case (act)
                ACT_TOGGLE: res = mode_is_plain(mode) ? ~lvl : lvl;
                ACT_CLEAR:  res = 1'b0;
                ACT_SET:    res = 1'b1;
                default:    res = lvl;
            endcase
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/ptc_cfg_regs.sv
`default_nettype none

module ptc_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ptc_pkg::CfgAddrW-1:0]    cfg_addr,
    input  wire logic [ptc_pkg::CfgDataW-1:0]    cfg_wdata,
    output ptc_pkg::cfg_t                        cfg
);
    import ptc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_WAVE_MODE:    cfg_next.wave_mode    = cfg_wdata[ModeW-1:0];
                REG_CLOCK_SELECT: cfg_next.clock_select = cfg_wdata[CsW-1:0];
                REG_ACTION_A:     cfg_next.action_a     = cfg_wdata[ActW-1:0];
                REG_ACTION_B:     cfg_next.action_b     = cfg_wdata[ActW-1:0];
                REG_DRIVE_A:      cfg_next.drive_a      = cfg_wdata[0];
                REG_DRIVE_B:      cfg_next.drive_b      = cfg_wdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/ptc_core.sv
`default_nettype none

module ptc_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ptc_pkg::cfg_t                 cfg,
    input  wire logic                          step,
    input  wire logic [ptc_pkg::CmdW-1:0]      cmd,
    input  wire logic [ptc_pkg::CountW-1:0]    value,
    output ptc_pkg::result_t                   result
);
    import ptc_pkg::*;

    logic [PhaseW-1:0] phase_reg,   phase_next;
    logic [CountW-1:0] counter_reg, counter_next;
    logic [CountW-1:0] buf_a_reg,   buf_a_next;
    logic [CountW-1:0] buf_b_reg,   buf_b_next;
    logic [CountW-1:0] act_a_reg,   act_a_next;
    logic [CountW-1:0] act_b_reg,   act_b_next;
    logic              level_a_reg, level_a_next;
    logic              level_b_reg, level_b_next;

    logic [PhaseW-1:0] phase_inc;
    logic              due;
    logic [CountW-1:0] top;
    logic [CountW:0]   count_inc;
    logic              wrap;
    logic              wrap_a, wrap_b;
    logic              match_a, match_b;

    assign phase_inc = phase_reg + PhaseW'(1);

    always_comb begin
        case (cfg.clock_select)
            CS_DIV1:    due = 1'b1;
            CS_DIV8:    due = (phase_inc[2:0] == '0);
            CS_DIV64:   due = (phase_inc[5:0] == '0);
            CS_DIV256:  due = (phase_inc[7:0] == '0);
            CS_DIV1024: due = (phase_inc == '0);
            default:    due = 1'b0;
        endcase
    end

    assign top       = mode_top_is_ocr(cfg.wave_mode) ? act_a_reg : COUNT_MAX;
    assign count_inc = {1'b0, counter_reg} + (CountW+1)'(1);

    always_comb begin
        phase_next   = phase_reg;
        counter_next = counter_reg;
        buf_a_next   = buf_a_reg;
        buf_b_next   = buf_b_reg;
        act_a_next   = act_a_reg;
        act_b_next   = act_b_reg;
        level_a_next = level_a_reg;
        level_b_next = level_b_reg;
        wrap         = 1'b0;
        wrap_a       = level_a_reg;
        wrap_b       = level_b_reg;
        match_a      = 1'b0;
        match_b      = 1'b0;

        case (cmd)
            CMD_WR_A: buf_a_next = value;
            CMD_WR_B: buf_b_next = value;
            CMD_TICK: begin
                phase_next = phase_inc;
                if (due) begin
                    wrap = (count_inc > {1'b0, top});
                    if (wrap) begin
                        counter_next = '0;
                        act_a_next   = buf_a_reg;
                        act_b_next   = buf_b_reg;
                        if (mode_is_pwm(cfg.wave_mode)) begin
                            if (cfg.drive_a) begin
                                wrap_a = wrap_action(cfg.action_a, level_a_reg);
                            end
                            if (cfg.drive_b) begin
                                wrap_b = wrap_action(cfg.action_b, level_b_reg);
                            end
                        end
                    end else begin
                        counter_next = count_inc[CountW-1:0];
                    end
                    // The match action is applied after the wrap action, so it wins.
                    match_a = (counter_next == act_a_next);
                    match_b = (counter_next == act_b_next);
                    level_a_next = (match_a && cfg.drive_a) ?
                        match_action(cfg.wave_mode, cfg.action_a, wrap_a) : wrap_a;
                    level_b_next = (match_b && cfg.drive_b) ?
                        match_action(cfg.wave_mode, cfg.action_b, wrap_b) : wrap_b;
                end
            end
            default: phase_next = phase_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            counter_reg <= '0;
            buf_a_reg   <= '0;
            buf_b_reg   <= '0;
            act_a_reg   <= '0;
            act_b_reg   <= '0;
            level_a_reg <= 1'b0;
            level_b_reg <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            counter_reg <= counter_next;
            buf_a_reg   <= buf_a_next;
            buf_b_reg   <= buf_b_next;
            act_a_reg   <= act_a_next;
            act_b_reg   <= act_b_next;
            level_a_reg <= level_a_next;
            level_b_reg <= level_b_next;
        end
    end

    always_comb begin
        result.count         = counter_next;
        result.overflow_flag = wrap;
        result.match_a_flag  = match_a;
        result.match_b_flag  = match_b;
        result.pin_a         = level_a_next;
        result.pin_b         = level_b_next;
    end

endmodule

`default_nettype wire

### rtl/pwm_timer_counter_8bit_top.sv
// An accepted transfer reaches m_tdata through the input register, then the result register,
// and is held there while m_tready is low. Throughput: one transfer per cycle while m_tready
// is high; the counter update is a single increment and compare.
// Reset: aresetn is synchronous and active low; it clears the counter, prescaler phase,
// compare buffers, active compares, pin levels, configuration and both valid flags.
`default_nettype none

module pwm_timer_counter_8bit_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // value[7:0]
    input  wire logic [ptc_pkg::CmdW-1:0]        s_tuser,   // cmd[1:0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // count[7:0], overflow_flag[8], match_a_flag[9], match_b_flag[10], pin_a[11],
    // pin_b[12], zeros[15:13]
    output logic [15:0]                          m_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ptc_pkg::CfgAddrW-1:0]    cfg_addr,
    input  wire logic [ptc_pkg::CfgDataW-1:0]    cfg_wdata
);
    import ptc_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic              in_valid_reg;
    logic [CmdW-1:0]   in_cmd_reg;
    logic [CountW-1:0] in_value_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ptc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ptc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (advance),
        .cmd     (in_cmd_reg),
        .value   (in_value_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= s_tuser;
            in_value_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

`ifndef SYNTHESIS
    // With the result register empty the block must always take a new transfer.
    assert property (@(posedge aclk) disable iff (!aresetn) !m_tvalid |-> s_tready)
        else $error("input stalled while result register empty");

    // A wrap always leaves the counter at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[7:0] == '0)
        else $error("overflow reported with non-zero count");

    // A result only appears after an item has passed the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result produced without an input item");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !in_valid_reg)
        else $error("valid flags not cleared by reset");
`endif

endmodule

`default_nettype wire

### bench/pwm_timer_counter_8bit_top_tb.sv
`timescale 1ns / 1ps

module pwm_timer_counter_8bit_top_tb;

    import ptc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE_WAIT  = 4;

    // Codes that the package leaves unnamed.
    localparam logic [CmdW-1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [ModeW-1:0] MODE_RSVD_LO = 3'd4;
    localparam logic [ModeW-1:0] MODE_RSVD_HI = 3'd6;
    localparam logic [CsW-1:0]   CS_STOP      = 3'd0;
    localparam logic [CsW-1:0]   CS_STOP_HI   = 3'd7;

    localparam result_t IDLE_RESULT = '0;

    typedef struct packed {
        logic            is_reg;
        logic [2:0]      code;
        logic [7:0]      data;
        logic            known;
        result_t         want;
    } plan_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic [CmdW-1:0]      s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CfgAddrW-1:0]  cfg_addr  = '0;
    logic [CfgDataW-1:0]  cfg_wdata = '0;

    pwm_timer_counter_8bit_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicted timer state, kept in step with every accepted transfer.
    cfg_t         timer_setup    = '0;
    logic [9:0]   prescale_phase = '0;
    logic [7:0]   timer_count    = '0;
    logic [7:0]   cmp_a_pending  = '0;
    logic [7:0]   cmp_b_pending  = '0;
    logic [7:0]   cmp_a_live     = '0;
    logic [7:0]   cmp_b_live     = '0;
    logic         pin_a_level    = 1'b0;
    logic         pin_b_level    = 1'b0;

    result_t      pending_results [$];
    plan_row_t    directed_plan [$];

    int           cycle_count    = 0;
    int           faults         = 0;
    int           items_sent     = 0;
    int           results_seen   = 0;
    int           wraps_seen     = 0;
    int           matches_seen   = 0;
    int           setups_run     = 0;
    int           hold_requests  = 0;
    int           hold_served    = 0;
    int           hold_left      = 0;
    logic         quiet          = 1'b0;
    result_t      got_result;
    result_t      want_result;

    function automatic logic pin_after_wrap(input logic [ActW-1:0] act, input logic lvl);
        case (act)
            ACT_CLEAR: return 1'b1;
            ACT_SET:   return 1'b0;
            default:   return lvl;
        endcase
    endfunction

    function automatic logic pin_after_match(input logic [ActW-1:0] act, input logic lvl,
                                             input logic pwm, input logic plain);
        logic res;
        res = lvl;
        if (plain || pwm) begin
            case (act)
                ACT_TOGGLE: res = plain ? ~lvl : lvl;
                ACT_CLEAR:  res = 1'b0;
                ACT_SET:    res = 1'b1;
                default:    res = lvl;
            endcase
        end
        return res;
    endfunction

    function automatic result_t timer_step(input logic [CmdW-1:0] cmd, input logic [7:0] val);
        result_t     r;
        logic [8:0]  next_count;
        logic [8:0]  top;
        logic        due;
        logic        pwm;
        logic        plain;
        r = '0;
        due = 1'b0;
        // The PWM modes are exactly the odd mode codes.
        pwm = timer_setup.wave_mode[0];
        plain = (timer_setup.wave_mode == MODE_NORMAL) || (timer_setup.wave_mode == MODE_CTC);
        case (cmd)
            CMD_WR_A: cmp_a_pending = val;
            CMD_WR_B: cmp_b_pending = val;
            CMD_TICK: begin
                prescale_phase = prescale_phase + 10'd1;
                case (timer_setup.clock_select)
                    CS_DIV1:    due = 1'b1;
                    CS_DIV8:    due = (prescale_phase[2:0] == '0);
                    CS_DIV64:   due = (prescale_phase[5:0] == '0);
                    CS_DIV256:  due = (prescale_phase[7:0] == '0);
                    CS_DIV1024: due = (prescale_phase == '0);
                    default:    due = 1'b0;
                endcase
                if (due) begin
                    if (timer_setup.wave_mode == MODE_CTC ||
                        timer_setup.wave_mode == MODE_PWM_PC_OCR ||
                        timer_setup.wave_mode == MODE_PWM_FAST_OCR) begin
                        top = {1'b0, cmp_a_live};
                    end else begin
                        top = 9'd255;
                    end
                    next_count = {1'b0, timer_count} + 9'd1;
                    if (next_count > top) begin
                        r.overflow_flag = 1'b1;
                        timer_count = '0;
                        cmp_a_live = cmp_a_pending;
                        cmp_b_live = cmp_b_pending;
                        if (pwm) begin
                            if (timer_setup.drive_a)
                                pin_a_level = pin_after_wrap(timer_setup.action_a, pin_a_level);
                            if (timer_setup.drive_b)
                                pin_b_level = pin_after_wrap(timer_setup.action_b, pin_b_level);
                        end
                    end else begin
                        timer_count = next_count[7:0];
                    end
                    // A match on the wrap tick is applied last, so it overrides the wrap.
                    if (timer_count == cmp_a_live) begin
                        r.match_a_flag = 1'b1;
                        if (timer_setup.drive_a)
                            pin_a_level = pin_after_match(timer_setup.action_a, pin_a_level,
                                                          pwm, plain);
                    end
                    if (timer_count == cmp_b_live) begin
                        r.match_b_flag = 1'b1;
                        if (timer_setup.drive_b)
                            pin_b_level = pin_after_match(timer_setup.action_b, pin_b_level,
                                                          pwm, plain);
                    end
                end
            end
            default: ;
        endcase
        r.count = timer_count;
        r.pin_a = pin_a_level;
        r.pin_b = pin_b_level;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [CfgAddrW-1:0] idx,
                                          input logic [CfgDataW-1:0] val);
        plan_row_t row;
        row = '0;
        row.is_reg = 1'b1;
        row.code = idx;
        row.data = 8'(val);
        return row;
    endfunction

    function automatic plan_row_t item_row(input logic [CmdW-1:0] cmd, input logic [7:0] val);
        plan_row_t row;
        row = '0;
        row.code = 3'(cmd);
        row.data = val;
        return row;
    endfunction

    function automatic plan_row_t known_row(input logic [CmdW-1:0] cmd, input logic [7:0] val,
                                            input result_t want);
        plan_row_t row;
        row = item_row(cmd, val);
        row.known = 1'b1;
        row.want = want;
        return row;
    endfunction

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_WAVE_MODE:    timer_setup.wave_mode    = val;
            REG_CLOCK_SELECT: timer_setup.clock_select = val;
            REG_ACTION_A:     timer_setup.action_a     = val[ActW-1:0];
            REG_ACTION_B:     timer_setup.action_b     = val[ActW-1:0];
            REG_DRIVE_A:      timer_setup.drive_a      = val[0];
            REG_DRIVE_B:      timer_setup.drive_b      = val[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setup(input cfg_t c);
        write_reg(REG_WAVE_MODE, c.wave_mode);
        write_reg(REG_CLOCK_SELECT, c.clock_select);
        write_reg(REG_ACTION_A, CfgDataW'(c.action_a));
        write_reg(REG_ACTION_B, CfgDataW'(c.action_b));
        write_reg(REG_DRIVE_A, CfgDataW'(c.drive_a));
        write_reg(REG_DRIVE_B, CfgDataW'(c.drive_b));
        setups_run++;
    endtask

    // Stop offering and wait until the block has returned every outstanding result.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic send_item(input logic [CmdW-1:0] cmd, input logic [7:0] val,
                             input logic known, input result_t want);
        result_t predicted;
        if (!quiet) begin
            while ($urandom_range(99) < 6) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = timer_step(cmd, val);
        pending_results.push_back(known ? want : predicted);
        items_sent++;
    endtask

    task automatic send_random_item();
        logic [CmdW-1:0] cmd;
        logic [7:0]      val;
        int              roll;
        roll = $urandom_range(99);
        val = 8'($urandom_range(255));
        if (roll < 72) begin
            cmd = CMD_TICK;
        end else if (roll < 84) begin
            cmd = CMD_WR_A;
            if ($urandom_range(1) != 0) val = 8'($urandom_range(15));
        end else if (roll < 96) begin
            cmd = CMD_WR_B;
            if ($urandom_range(1) != 0) val = 8'($urandom_range(15));
        end else begin
            cmd = CMD_UNUSED;
        end
        send_item(cmd, val, 1'b0, IDLE_RESULT);
    endtask

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // The receiver: rare random stalls, one long requested hold, none while quiet.
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result = m_tdata[$bits(result_t)-1:0];
            if (pending_results.size() == 0) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("unexpected result transfer 0x%04h at cycle %0d",
                             m_tdata, cycle_count);
            end else begin
                want_result = pending_results.pop_front();
                results_seen++;
                if (got_result.overflow_flag) wraps_seen++;
                if (got_result.match_a_flag || got_result.match_b_flag) matches_seen++;
                if (got_result.count !== want_result.count ||
                    got_result.overflow_flag !== want_result.overflow_flag ||
                    got_result.match_a_flag !== want_result.match_a_flag ||
                    got_result.match_b_flag !== want_result.match_b_flag ||
                    got_result.pin_a !== want_result.pin_a ||
                    got_result.pin_b !== want_result.pin_b ||
                    m_tdata[15:$bits(result_t)] !== '0) begin
                    faults++;
                    if (faults <= REPORT_LIMIT)
                        $display({"result %0d mismatch: expected count=%0d ovf=%b ma=%b mb=%b ",
                                  "pa=%b pb=%b, got count=%0d ovf=%b ma=%b mb=%b pa=%b pb=%b ",
                                  "pad=%b"},
                                 results_seen, want_result.count, want_result.overflow_flag,
                                 want_result.match_a_flag, want_result.match_b_flag,
                                 want_result.pin_a, want_result.pin_b, got_result.count,
                                 got_result.overflow_flag, got_result.match_a_flag,
                                 got_result.match_b_flag, got_result.pin_a, got_result.pin_b,
                                 m_tdata[15:$bits(result_t)]);
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        // Straight after reset the clock is stopped, so every result is all zeros.
        directed_plan.push_back(known_row(CMD_TICK, 8'h00, IDLE_RESULT));
        directed_plan.push_back(known_row(CMD_WR_A, 8'hFF, IDLE_RESULT));
        directed_plan.push_back(known_row(CMD_WR_B, 8'h00, IDLE_RESULT));
        directed_plan.push_back(known_row(CMD_UNUSED, 8'hFF, IDLE_RESULT));
        // Fast PWM with TOP from compare A at zero: wrap and match fall on the same tick.
        directed_plan.push_back(reg_row(REG_WAVE_MODE, MODE_PWM_FAST_OCR));
        directed_plan.push_back(reg_row(REG_CLOCK_SELECT, CS_DIV1));
        directed_plan.push_back(reg_row(REG_ACTION_A, CfgDataW'(ACT_CLEAR)));
        directed_plan.push_back(reg_row(REG_ACTION_B, CfgDataW'(ACT_SET)));
        directed_plan.push_back(reg_row(REG_DRIVE_A, 3'd1));
        directed_plan.push_back(reg_row(REG_DRIVE_B, 3'd1));
        directed_plan.push_back(item_row(CMD_WR_A, 8'h00));
        directed_plan.push_back(item_row(CMD_WR_B, 8'h00));
        directed_plan.push_back(item_row(CMD_TICK, 8'h00));
        directed_plan.push_back(item_row(CMD_TICK, 8'hFF));
        // Toggle has no effect in a PWM mode.
        directed_plan.push_back(reg_row(REG_ACTION_A, CfgDataW'(ACT_TOGGLE)));
        directed_plan.push_back(item_row(CMD_TICK, 8'h00));
        // Clear on compare match with a short period, toggling pin A.
        directed_plan.push_back(reg_row(REG_WAVE_MODE, MODE_CTC));
        directed_plan.push_back(item_row(CMD_WR_A, 8'h03));
        directed_plan.push_back(item_row(CMD_WR_B, 8'h01));
        repeat (5) directed_plan.push_back(item_row(CMD_TICK, 8'h00));
        // Run past the compare A value in normal mode, then return: the counter is above TOP.
        directed_plan.push_back(reg_row(REG_WAVE_MODE, MODE_NORMAL));
        repeat (5) directed_plan.push_back(item_row(CMD_TICK, 8'h00));
        directed_plan.push_back(reg_row(REG_WAVE_MODE, MODE_CTC));
        directed_plan.push_back(item_row(CMD_TICK, 8'h00));
        // Reserved modes never move the pins; a reserved clock select stops the timer.
        directed_plan.push_back(reg_row(REG_WAVE_MODE, MODE_RSVD_HI));
        repeat (2) directed_plan.push_back(item_row(CMD_TICK, 8'h00));
        directed_plan.push_back(reg_row(REG_WAVE_MODE, MODE_RSVD_LO));
        directed_plan.push_back(reg_row(REG_CLOCK_SELECT, CS_STOP_HI));
        directed_plan.push_back(item_row(CMD_TICK, 8'h00));
    end

    initial begin
        cfg_t setup;
        int   n_items;
        int   directed_items;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_reg) begin
                drain();
                write_reg(directed_plan[i].code, directed_plan[i].data[CfgDataW-1:0]);
            end else begin
                send_item(directed_plan[i].code[CmdW-1:0], directed_plan[i].data,
                          directed_plan[i].known, directed_plan[i].want);
            end
        end
        directed_items = items_sent;

        for (int p = 0; p < 10; p++) begin
            setup.wave_mode    = ModeW'($urandom_range(7));
            setup.clock_select = ($urandom_range(3) != 0) ? CS_DIV1 : CsW'($urandom_range(7));
            setup.action_a     = ActW'($urandom_range(3));
            setup.action_b     = ActW'($urandom_range(3));
            setup.drive_a      = 1'($urandom_range(1));
            setup.drive_b      = 1'($urandom_range(1));
            n_items = $urandom_range(15, 35);
            if (p == 0) begin
                setup = '{MODE_PWM_FAST_OCR, CS_DIV1, ACT_SET, ACT_SET, 1'b1, 1'b1};
            end else if (p == 1) begin
                setup = '{MODE_NORMAL, CS_DIV8, ACT_NONE, ACT_NONE, 1'b0, 1'b0};
            end else if (p == 2) begin
                // Fast PWM with TOP fixed at its maximum.
                setup = '{MODE_PWM_FAST, CS_DIV1, ACT_CLEAR, ACT_SET, 1'b1, 1'b1};
                n_items = 60;
            end
            drain();
            apply_setup(setup);
            // Hold the result side off long enough for the input to stall behind it.
            if (p == 2) hold_requests <= hold_requests + 1;
            repeat (n_items) send_random_item();
        end

        // A run with no idling on either side and a divided timer clock.
        drain();
        quiet <= 1'b1;
        apply_setup('{MODE_CTC, CS_DIV8, ACT_TOGGLE, ACT_CLEAR, 1'b1, 1'b1});
        repeat (60) send_random_item();
        drain();
        apply_setup('{MODE_PWM_PC, CS_STOP, ACT_NONE, ACT_CLEAR, 1'b0, 1'b1});
        repeat (20) send_random_item();
        drain();

        $display("Drove %0d transfers (%0d directed) under %0d timer setups; %0d results checked.",
                 items_sent, directed_items, setups_run, results_seen);
        $display("Saw %0d counter wraps and %0d compare matches; %0d faults found.",
                 wraps_seen, matches_seen, faults);
        if (faults == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
